/* rtl/seeded_add_xor_byte_cipher_core_defines.svh */
// ----------------------------------------------------------------------------
// seeded_add_xor_byte_cipher_core_defines
// Assertion macros used by the cipher core RTL.
// ----------------------------------------------------------------------------
`ifndef SEEDED_ADD_XOR_BYTE_CIPHER_CORE_DEFINES_SVH
`define SEEDED_ADD_XOR_BYTE_CIPHER_CORE_DEFINES_SVH

// same-cycle implication
`define SACB_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SACB_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sacb_pkg.sv */
// ----------------------------------------------------------------------------
// sacb_pkg
// Types, constants and key generator functions of the byte cipher core.
// ----------------------------------------------------------------------------
`default_nettype none

package sacb_pkg;

  localparam int unsigned STEPS_PER_KEY_BYTE = 32;
  localparam logic [8:0]  MAX_KEY_LENGTH     = 9'd256;

  localparam logic [1:0] REG_SEED       = 2'd0;
  localparam logic [1:0] REG_DIRECTION  = 2'd1;
  localparam logic [1:0] REG_KEY_LENGTH = 2'd2;

  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  typedef struct packed {
    logic [31:0] seed;
    logic        direction;
    logic [8:0]  key_length;
  } cfg_t;

  typedef struct packed {
    logic [31:0] generator_word;
    logic [7:0]  key_position;
  } state_t;

  typedef struct packed {
    logic   en;
    state_t data;
  } state_wr_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result_byte;
  } out_item_t;

  function automatic logic [31:0] shift_once(input logic [31:0] w);
    logic fb;
    fb = w[0] ^ w[1] ^ w[2] ^ w[3] ^ w[5] ^ w[7];
    return {w[0], w[31:2], fb};
  endfunction

  // linear map over GF(2): flattens to a shallow XOR network
  function automatic logic [31:0] advance_key(input logic [31:0] w);
    logic [31:0] v;
    v = w;
    for (int unsigned n = 0; n < STEPS_PER_KEY_BYTE; n++) begin
      v = shift_once(v);
    end
    return v;
  endfunction

  function automatic logic [8:0] eff_length(input logic [8:0] len);
    if (len == 9'd0 || len > MAX_KEY_LENGTH) begin
      return MAX_KEY_LENGTH;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

/* rtl/sacb_stream_if.sv */
// ----------------------------------------------------------------------------
// sacb_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface sacb_stream_if #(parameter type payload_t = logic [7:0]) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/sacb_regs.sv */
// ----------------------------------------------------------------------------
// sacb_regs
// APB-style configuration registers: seed, direction, key length.
// ----------------------------------------------------------------------------
`default_nettype none

module sacb_regs
  import sacb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [1:0] reg_idx;
  logic       wr_en;
  cfg_t       regs;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.seed       <= '0;
      regs.direction  <= DIR_ENCRYPT;
      regs.key_length <= 9'd16;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SEED:       regs.seed       <= pwdata;
        REG_DIRECTION:  regs.direction  <= pwdata[0];
        REG_KEY_LENGTH: regs.key_length <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SEED:       prdata = regs.seed;
      REG_DIRECTION:  prdata = {31'd0, regs.direction};
      REG_KEY_LENGTH: prdata = {23'd0, regs.key_length};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/sacb_state_mem.sv */
// ----------------------------------------------------------------------------
// sacb_state_mem
// Generator state store: one-entry synchronous memory, registered read,
// write forwarding, reads as zero until first written.
// ----------------------------------------------------------------------------
`default_nettype none

module sacb_state_mem
  import sacb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire state_wr_t wr,
  output state_t         rd_state
);

  state_t mem [0:0];
  logic   mem_valid;
  state_t rd_q;
  logic   rd_ok;
  logic   fwd_valid;
  state_t fwd_data;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[0] <= wr.data;
    end
    rd_q     <= mem[0];
    fwd_data <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= 1'b0;
      rd_ok     <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        mem_valid <= 1'b1;
      end
      rd_ok     <= mem_valid;
      fwd_valid <= wr.en;
    end
  end

  always_comb begin
    if (fwd_valid) begin
      rd_state = fwd_data;
    end else if (rd_ok) begin
      rd_state = rd_q;
    end else begin
      rd_state = '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/sacb_xform.sv */
// ----------------------------------------------------------------------------
// sacb_xform
// Key stage and output register: advances the generator, transforms the byte,
// writes the next state back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "seeded_add_xor_byte_cipher_core_defines.svh"

module sacb_xform
  import sacb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire state_t cur_state,
  output state_wr_t   wr,
  sacb_stream_if.sink   item_in,
  sacb_stream_if.source result_out
);

  logic        s1_valid;
  in_item_t    s1_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        out_free;
  logic        s1_fire;
  logic        accept;
  state_t      base;
  logic [31:0] gen_adv;
  logic [7:0]  key;
  logic [7:0]  res;
  logic [8:0]  eff_len;
  logic [8:0]  next_pos;
  logic        wrap;

  assign out_free      = !out_valid || result_out.ready;
  assign s1_fire       = s1_valid && out_free;
  assign item_in.ready = !s1_valid || out_free;
  assign accept        = item_in.valid && item_in.ready;

  assign result_out.valid   = out_valid;
  assign result_out.payload = out_item;

  always_comb begin
    if (s1_item.start_of_message) begin
      base.generator_word = cfg.seed;
      base.key_position   = '0;
    end else begin
      base = cur_state;
    end
    gen_adv  = advance_key(base.generator_word);
    key      = gen_adv[7:0];
    if (cfg.direction == DIR_DECRYPT) begin
      res = (s1_item.data_byte ^ key) - key;
    end else begin
      res = (s1_item.data_byte + key) ^ key;
    end
    eff_len  = eff_length(cfg.key_length);
    next_pos = {1'b0, base.key_position} + 9'd1;
    wrap     = next_pos >= eff_len;
    wr.en    = s1_fire;
    if (wrap) begin
      wr.data.generator_word = cfg.seed;
      wr.data.key_position   = '0;
    end else begin
      wr.data.generator_word = gen_adv;
      wr.data.key_position   = next_pos[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (item_in.ready) begin
        s1_valid <= item_in.valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item_in.payload;
    end
    if (s1_fire) begin
      out_item.result_byte <= res;
    end
  end

  `SACB_ASSERT_NXT(a_fire_to_out, clk, rst, s1_fire, out_valid, "advance lost result")
  `SACB_ASSERT_IMP(a_pos_bound, clk, rst, wr.en, ({1'b0, wr.data.key_position} < eff_len),
                   "key position beyond key length")
  `SACB_ASSERT_IMP(a_wrap_reload, clk, rst, wr.en && wr.data.key_position == 8'd0,
                   wr.data.generator_word == cfg.seed, "wrap without seed reload")

endmodule

`default_nettype wire

/* rtl/seeded_add_xor_byte_cipher_core.sv */
// A byte accepted on item_in is held in the key stage register, then in the output register that drives result_out.
// Throughput: one byte per cycle while result_out is ready, set by the read-modify-write of the
//   generator state entry, with the last write forwarded past the memory read register.
// Reset: synchronous; registers return to seed 0, encrypt, key length 16; generator
//   state reads as zero until first written; pipeline empties.
// ----------------------------------------------------------------------------
// seeded_add_xor_byte_cipher_core
// Byte stream cipher with a seed-generated repeating key, top level.
// ----------------------------------------------------------------------------
`default_nettype none

module seeded_add_xor_byte_cipher_core
  import sacb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  sacb_stream_if.sink      item_in,
  sacb_stream_if.source    result_out
);

  cfg_t      cfg;
  state_t    cur_state;
  state_wr_t wr;

  sacb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sacb_state_mem u_state_mem (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_state (cur_state)
  );

  sacb_xform u_xform (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cur_state  (cur_state),
    .wr         (wr),
    .item_in    (item_in),
    .result_out (result_out)
  );

endmodule

`default_nettype wire

/* tb/tb_seeded_add_xor_byte_cipher_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_seeded_add_xor_byte_cipher_core
// Self-checking bench for the seeded add/xor byte cipher core.
// Bytes go in through a valid/ready driver fed from a queue; a clocked monitor
// compares each output transaction against a bit-accurate key generator and
// cipher model kept in step with the APB register settings. A directed
// sequence hits byte extremes, both directions, key length wrap and
// out-of-range lengths, and mid-message register changes. Random phases
// follow under three idle/stall patterns.
// ----------------------------------------------------------------------------

module tb_seeded_add_xor_byte_cipher_core
  import sacb_pkg::*;
();

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sacb_stream_if #(.payload_t(in_item_t))  item_if ();
  sacb_stream_if #(.payload_t(out_item_t)) res_if ();

  seeded_add_xor_byte_cipher_core DUT (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .item_in    (item_if),
    .result_out (res_if)
  );

  always #5 clk = ~clk;

  // register shadows and cipher state
  logic [31:0] seed_reg;
  logic        dir_reg;
  logic [8:0]  klen_reg;
  logic [31:0] key_word;
  logic [7:0]  key_pos;

  in_item_t   bytes_to_send[$];
  logic [7:0] expected_cipher[$];
  logic [7:0] want_byte;

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned n_errors;
  int unsigned n_items;
  int unsigned n_checked;
  int unsigned n_msgs;
  int unsigned n_writes;

  function automatic logic [7:0] cipher_byte(input in_item_t it);
    logic [31:0] w;
    logic [7:0]  k;
    logic [7:0]  r;
    logic [8:0]  lim;
    logic [8:0]  nxt;
    logic        fb;
    if (it.start_of_message) begin
      key_pos  = 8'd0;
      key_word = seed_reg;
    end
    w = key_word;
    for (int i = 0; i < 32; i++) begin
      fb = w[7] ^ w[5] ^ w[3] ^ w[2] ^ w[1] ^ w[0];
      w  = {w[0], w[31:1]};
      w[0] = fb;
    end
    key_word = w;
    k = w[7:0];
    if (dir_reg == DIR_ENCRYPT) begin
      r = (it.data_byte + k) ^ k;
    end else begin
      r = (it.data_byte ^ k) - k;
    end
    lim = (klen_reg == 9'd0 || klen_reg > 9'd256) ? 9'd256 : klen_reg;
    nxt = {1'b0, key_pos} + 9'd1;
    if (nxt >= lim) begin
      key_pos  = 8'd0;
      key_word = seed_reg;
    end else begin
      key_pos = nxt[7:0];
    end
    return r;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      item_if.valid <= 1'b0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        expected_cipher.push_back(cipher_byte(item_if.payload));
        void'(bytes_to_send.pop_front());
        n_items++;
      end
      if (item_if.valid && !item_if.ready) begin
        // hold until taken
      end else if (bytes_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        item_if.valid   <= 1'b1;
        item_if.payload <= bytes_to_send[0];
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_cipher.size() == 0) begin
          $display("%0t: unexpected result_byte, expected none, got %02h",
                   $time, res_if.payload.result_byte);
          n_errors++;
        end else begin
          want_byte = expected_cipher.pop_front();
          if (res_if.payload.result_byte !== want_byte) begin
            $display("%0t: result_byte mismatch, expected %02h, got %02h",
                     $time, want_byte, res_if.payload.result_byte);
            n_errors++;
          end
          n_checked++;
        end
      end
      res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic queue_byte(input logic [7:0] d, input logic som);
    in_item_t it;
    it.data_byte        = d;
    it.start_of_message = som;
    bytes_to_send.push_back(it);
    if (som) n_msgs++;
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SEED:       seed_reg = val;
      REG_DIRECTION:  dir_reg  = val[0];
      REG_KEY_LENGTH: klen_reg = val[8:0];
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic drain();
    while (bytes_to_send.size() != 0 || expected_cipher.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [31:0] seed_val;
    logic [31:0] len_val;
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    seed_reg        = 32'd0;
    dir_reg         = DIR_ENCRYPT;
    klen_reg        = 9'd16;
    key_word        = 32'd0;
    key_pos         = 8'd0;
    n_errors        = 0;
    n_items         = 0;
    n_checked       = 0;
    n_msgs          = 0;
    n_writes        = 0;
    src_idle_pct    = 18;
    snk_idle_pct    = 60;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // bytes ahead of any message start run on the reset state
    @(negedge clk);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    drain();

    // key length 1: reload after every byte
    reg_write(REG_SEED, 32'hFFFF_FFFF);
    reg_write(REG_KEY_LENGTH, 32'd1);
    @(negedge clk);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b0);
    drain();

    reg_write(REG_SEED, 32'hA5C3_0F1E);
    reg_write(REG_DIRECTION, 32'(DIR_DECRYPT));
    reg_write(REG_KEY_LENGTH, 32'd256);
    @(negedge clk);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h01, 1'b0);
    drain();

    // zero and oversize lengths act as 256
    reg_write(REG_SEED, 32'h0000_0001);
    reg_write(REG_DIRECTION, 32'(DIR_ENCRYPT));
    reg_write(REG_KEY_LENGTH, 32'd0);
    @(negedge clk);
    queue_byte(8'h7F, 1'b1);
    queue_byte(8'hFE, 1'b0);
    drain();

    reg_write(REG_DIRECTION, 32'(DIR_DECRYPT));
    reg_write(REG_KEY_LENGTH, 32'd511);
    @(negedge clk);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hAA, 1'b1);
    drain();

    // get the position to 10, then shrink the length and swap the seed
    reg_write(REG_DIRECTION, 32'(DIR_ENCRYPT));
    reg_write(REG_KEY_LENGTH, 32'd40);
    @(negedge clk);
    for (int i = 0; i < 10; i++) queue_byte(8'(i * 29), i == 0);
    drain();
    reg_write(REG_SEED, 32'h1234_5678);
    reg_write(REG_KEY_LENGTH, 32'd5);
    @(negedge clk);
    queue_byte(8'h3C, 1'b0);
    queue_byte(8'hC3, 1'b0);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        src_idle_pct = 60;
        snk_idle_pct = 18;
      end else if (ph == 6) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      case ($urandom_range(3))
        0:       seed_val = 32'd0;
        1:       seed_val = 32'hFFFF_FFFF;
        default: seed_val = $urandom;
      endcase
      case ($urandom_range(7))
        0:       len_val = 32'd1;
        1:       len_val = 32'd256;
        2:       len_val = 32'd0;
        3:       len_val = 32'd511;
        4:       len_val = 32'd257;
        5, 6:    len_val = $urandom_range(12, 2);
        default: len_val = $urandom_range(511);
      endcase
      reg_write(REG_SEED, seed_val);
      reg_write(REG_DIRECTION, $urandom_range(1));
      reg_write(REG_KEY_LENGTH, len_val);
      @(negedge clk);
      for (int j = 0; j < 64; j++) begin
        queue_byte(8'($urandom_range(255)),
                   (j == 0) ? 1'($urandom_range(1)) : ($urandom_range(11) == 0));
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d bytes in %0d messages with %0d register writes; %0d results checked.",
             n_items, n_msgs, n_writes, n_checked);
    $display("Covered both directions, key lengths 0/1/256/511 plus random ones, three stall patterns.");
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout waiting for transactions to complete.");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
